### rtl/core/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// types and constants shared by the best candidate selector
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam logic [4:0]         MIN_HITS_RST = 5'd3;
	localparam logic signed [11:0] PHI_NO_LIK   = 12'sd1024;
	localparam logic signed [14:0] PHI_NONE     = 15'sd9999;
	localparam logic signed [3:0]  LAYER_NONE   = -4'sd1;

	// register index of min_hits (byte address / 4)
	localparam logic REG_MIN_HITS = 1'b0;

	typedef struct packed {
		logic [4:0]         hits;
		logic [15:0]        lik;
		logic signed [11:0] phi;
		logic signed [3:0]  layer;
	} inner_t;

	typedef struct packed {
		logic [4:0]         pt;
		logic signed [7:0]  eta;
		logic signed [14:0] phi;
		logic [15:0]        lik;
		logic [4:0]         hits;
		logic signed [1:0]  charge;
		logic signed [3:0]  layer;
	} result_t;

endpackage

### rtl/core/bcs_inner_sel.sv
// ----------------------------------------------------------------------------
// bcs_inner_sel
// running best-entry search within one pattern: most hits, then first
// strictly greatest nonzero likelihood
// ----------------------------------------------------------------------------
module bcs_inner_sel #(
	parameter int REF_LAYERS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               close,
	input  logic [4:0]         hit_count,
	input  logic [15:0]        likelihood_sum,
	input  logic signed [11:0] ref_phi,
	output bcs_pkg::inner_t    inner_nxt
);
	import bcs_pkg::*;

	localparam int LW = (REF_LAYERS > 1) ? $clog2(REF_LAYERS) : 1;
	localparam logic [LW-1:0] LAST_IDX = LW'(REF_LAYERS - 1);

	logic [LW-1:0] layer_cnt_q;
	inner_t        inner_q;
	logic          more_hits;
	logic          better_lik;
	logic signed [3:0] layer_now;

	assign layer_now  = signed'(4'(layer_cnt_q));
	assign more_hits  = hit_count > inner_q.hits;
	assign better_lik = (hit_count != 5'd0) && (hit_count == inner_q.hits) &&
		(likelihood_sum > inner_q.lik);

	always_comb begin
		inner_nxt = inner_q;
		if (more_hits) begin
			inner_nxt.hits = hit_count;
			if (likelihood_sum != 16'd0) begin
				inner_nxt.lik   = likelihood_sum;
				inner_nxt.phi   = ref_phi;
				inner_nxt.layer = layer_now;
			end else begin
				inner_nxt.lik   = 16'd0;
				inner_nxt.phi   = PHI_NO_LIK;
				inner_nxt.layer = LAYER_NONE;
			end
		end else if (better_lik) begin
			inner_nxt.lik   = likelihood_sum;
			inner_nxt.phi   = ref_phi;
			inner_nxt.layer = layer_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_cnt_q   <= '0;
			inner_q.hits  <= 5'd0;
			inner_q.lik   <= 16'd0;
			inner_q.phi   <= PHI_NO_LIK;
			inner_q.layer <= LAYER_NONE;
		end else if (step) begin
			if (close) begin
				layer_cnt_q   <= '0;
				inner_q.hits  <= 5'd0;
				inner_q.lik   <= 16'd0;
				inner_q.phi   <= PHI_NO_LIK;
				inner_q.layer <= LAYER_NONE;
			end else begin
				inner_q <= inner_nxt;
				if (layer_cnt_q < LAST_IDX) begin
					layer_cnt_q <= layer_cnt_q + LW'(1);
				end
			end
		end
	end

endmodule

### rtl/core/two_level_best_candidate_select.sv
// ----------------------------------------------------------------------------
// two_level_best_candidate_select
// picks the best reference-layer entry of each pattern and the best pattern
// of a set, emitting one candidate word per set
// ----------------------------------------------------------------------------
// One input word per cycle is taken unless the input stalls, with no gaps
// between words of a set. A word passes an input register, then the inner
// and outer compares run into the state and result registers; a candidate
// is valid once the word carrying s_tlast has passed the input and result
// registers. The result register lets the next set stream in while a candidate
// waits; input stalls only when a new candidate is ready while the previous
// one is still untaken. min_hits is at byte address 0 and resets to 3.
// ----------------------------------------------------------------------------
module two_level_best_candidate_select #(
	parameter int REF_LAYERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// hit_count, likelihood_sum, ref_phi, pattern_pt, pattern_eta, pattern_charge
	input  logic [47:0] s_tdata,
	input  logic        s_tlast,   // last_pattern
	input  logic        s_tuser,   // last_layer
	input  logic        s_tvalid,
	output logic        s_tready,
	// best_pt, best_eta, best_phi, best_likelihood, best_hits, best_charge,
	// best_ref_layer, zero pad
	output logic [55:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bcs_pkg::*;

	// config
	logic [4:0] min_hits_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_HITS) ? {27'd0, min_hits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q <= MIN_HITS_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_HITS)) begin
			min_hits_q <= pwdata[4:0];
		end
	end

	// input register
	logic               v_s1;
	logic [4:0]         hits_s1;
	logic [15:0]        lik_s1;
	logic signed [11:0] phi_s1;
	logic [14:0]        key_s1;
	logic               last_layer_s1;
	logic               last_pattern_s1;
	logic               adv;
	logic               step;
	logic               emit;

	assign adv      = !(last_pattern_s1 && m_tvalid && !m_tready);
	assign s_tready = !v_s1 || adv;
	assign step     = v_s1 && adv;
	assign emit     = step && last_pattern_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hits_s1         <= s_tdata[4:0];
			lik_s1          <= s_tdata[20:5];
			phi_s1          <= s_tdata[32:21];
			key_s1          <= {s_tdata[37:33], s_tdata[45:38], s_tdata[47:46]};
			last_layer_s1   <= s_tuser;
			last_pattern_s1 <= s_tlast;
		end
	end

	// inner level
	inner_t inner_nxt;
	logic   close;

	assign close = last_layer_s1 || last_pattern_s1;

	bcs_inner_sel #(
		.REF_LAYERS(REF_LAYERS)
	) u_inner (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.close         (close),
		.hit_count     (hits_s1),
		.likelihood_sum(lik_s1),
		.ref_phi       (phi_s1),
		.inner_nxt     (inner_nxt)
	);

	// outer level
	logic [4:0]         outer_hits_q;
	logic [15:0]        outer_lik_q;
	logic signed [14:0] outer_phi_q;
	logic signed [3:0]  outer_layer_q;
	logic [14:0]        outer_key_q;
	logic               take;
	result_t            res_nxt;
	result_t            res_q;
	logic               m_tvalid_q;

	assign take = close && (inner_nxt.hits >= min_hits_q) &&
		((inner_nxt.hits > outer_hits_q) ||
		 ((inner_nxt.hits == outer_hits_q) && (inner_nxt.lik > outer_lik_q)));

	always_comb begin
		res_nxt.pt     = outer_key_q[14:10];
		res_nxt.eta    = outer_key_q[9:2];
		res_nxt.charge = outer_key_q[1:0];
		res_nxt.phi    = outer_phi_q;
		res_nxt.lik    = outer_lik_q;
		res_nxt.hits   = outer_hits_q;
		res_nxt.layer  = outer_layer_q;
		if (take) begin
			res_nxt.pt     = key_s1[14:10];
			res_nxt.eta    = key_s1[9:2];
			res_nxt.charge = key_s1[1:0];
			res_nxt.phi    = {{3{inner_nxt.phi[11]}}, inner_nxt.phi};
			res_nxt.lik    = inner_nxt.lik;
			res_nxt.hits   = inner_nxt.hits;
			res_nxt.layer  = inner_nxt.layer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_hits_q  <= 5'd0;
			outer_lik_q   <= 16'd0;
			outer_phi_q   <= PHI_NONE;
			outer_layer_q <= LAYER_NONE;
			outer_key_q   <= 15'd0;
		end else if (emit) begin
			outer_hits_q  <= 5'd0;
			outer_lik_q   <= 16'd0;
			outer_phi_q   <= PHI_NONE;
			outer_layer_q <= LAYER_NONE;
			outer_key_q   <= 15'd0;
		end else if (step && take) begin
			outer_hits_q  <= inner_nxt.hits;
			outer_lik_q   <= inner_nxt.lik;
			outer_phi_q   <= {{3{inner_nxt.phi[11]}}, inner_nxt.phi};
			outer_layer_q <= inner_nxt.layer;
			outer_key_q   <= key_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.layer, res_q.charge, res_q.hits, res_q.lik,
		res_q.phi, res_q.eta, res_q.pt};

`ifndef SYNTHESIS
	a_word_from_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s1 && last_pattern_s1))
		else $error("result word without end of set");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_q.hits == 5'd0)) |-> ((res_q.phi == PHI_NONE) &&
		(res_q.layer == LAYER_NONE)))
		else $error("empty candidate carries a phi or layer");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(key_s1)))
		else $error("stalled input stage lost its word");

	a_outer_none: assert property (@(posedge clk) disable iff (!arst_n)
		(outer_phi_q == PHI_NONE) |-> (outer_hits_q == 5'd0))
		else $error("outer best has hits but no phi");
`endif

endmodule

### tb/tb_two_level_best_candidate_select.sv
// ----------------------------------------------------------------------------
// tb_two_level_best_candidate_select
// self-checking bench for the two-level best candidate selector
// ----------------------------------------------------------------------------
// Entry words are queued by the stimulus process and streamed in by a clocked
// driver with random idle bursts. Each accepted word is folded into a local
// model of the inner (per pattern) and outer (per set) argmax, which queues
// the expected candidate on the last word of a set. A clocked monitor applies
// random backpressure and compares every candidate word field by field.
// min_hits is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module tb_two_level_best_candidate_select;
	import bcs_pkg::*;

	localparam int REF_LAYERS  = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [4:0]         hits;
		logic [15:0]        lik;
		logic signed [11:0] phi;
		logic [4:0]         pt;
		logic signed [7:0]  eta;
		logic signed [1:0]  charge;
		logic               last_layer;
		logic               last_pattern;
	} entry_t;

	logic        clk;
	logic        arst_n = 1'b0;
	// hit_count, likelihood_sum, ref_phi, pattern_pt, pattern_eta, pattern_charge
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;   // last_pattern
	logic        s_tuser = 1'b0;   // last_layer
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// best_pt, best_eta, best_phi, best_likelihood, best_hits, best_charge,
	// best_ref_layer, zero pad
	logic [55:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	two_level_best_candidate_select #(
		.REF_LAYERS(REF_LAYERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	entry_t     entry_q[$];
	result_t    cand_q[$];
	entry_t     cur_entry;
	logic [4:0] need_hits;
	logic [2:0] layer_cnt;
	inner_t     pat_best;
	result_t    set_best;
	logic       idle_en = 1'b1;
	int         err_cnt = 0;
	int         src_gap = 0;
	int         sink_gap = 0;
	int         cycles = 0;

	function automatic void clear_pattern();
		layer_cnt      = '0;
		pat_best.hits  = '0;
		pat_best.lik   = '0;
		pat_best.phi   = PHI_NO_LIK;
		pat_best.layer = LAYER_NONE;
	endfunction

	function automatic void clear_set();
		set_best        = '0;
		set_best.phi    = PHI_NONE;
		set_best.layer  = LAYER_NONE;
	endfunction

	// running argmax over entries, then over finished patterns
	function automatic void fold_entry(entry_t e);
		logic signed [3:0] idx;
		idx = $signed({1'b0, layer_cnt});
		if (e.hits > pat_best.hits) begin
			pat_best.hits = e.hits;
			if (e.lik != 0) begin
				pat_best.lik   = e.lik;
				pat_best.phi   = e.phi;
				pat_best.layer = idx;
			end else begin
				pat_best.lik   = '0;
				pat_best.phi   = PHI_NO_LIK;
				pat_best.layer = LAYER_NONE;
			end
		end else if (e.hits != 0 && e.hits == pat_best.hits && e.lik > pat_best.lik) begin
			pat_best.lik   = e.lik;
			pat_best.phi   = e.phi;
			pat_best.layer = idx;
		end
		if (e.last_layer || e.last_pattern) begin
			if (pat_best.hits >= need_hits &&
			    (pat_best.hits > set_best.hits ||
			     (pat_best.hits == set_best.hits && pat_best.lik > set_best.lik))) begin
				set_best.hits   = pat_best.hits;
				set_best.lik    = pat_best.lik;
				set_best.phi    = {{3{pat_best.phi[11]}}, pat_best.phi};
				set_best.layer  = pat_best.layer;
				set_best.pt     = e.pt;
				set_best.eta    = e.eta;
				set_best.charge = e.charge;
			end
			clear_pattern();
		end else if (layer_cnt < 3'(REF_LAYERS - 1)) begin
			layer_cnt++;
		end
		if (e.last_pattern) begin
			cand_q = {cand_q, set_best};
			clear_set();
		end
	endfunction

	function automatic void cmp_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	function automatic void check_cand(logic [55:0] word);
		result_t exp_c;
		if (cand_q.size() == 0) begin
			$error("candidate word %h with nothing expected", word);
			err_cnt++;
			return;
		end
		exp_c = cand_q.pop_front();
		cmp_field("best_pt", exp_c.pt, word[4:0]);
		cmp_field("best_eta", exp_c.eta, $signed(word[12:5]));
		cmp_field("best_phi", exp_c.phi, $signed(word[27:13]));
		cmp_field("best_likelihood", exp_c.lik, word[43:28]);
		cmp_field("best_hits", exp_c.hits, word[48:44]);
		cmp_field("best_charge", exp_c.charge, $signed(word[50:49]));
		cmp_field("best_ref_layer", exp_c.layer, $signed(word[54:51]));
	endfunction

	function automatic void add_entry(logic [4:0] hits, logic [15:0] lik,
			logic signed [11:0] phi, logic [4:0] pt, logic signed [7:0] eta,
			logic signed [1:0] chg, logic ll, logic lp);
		entry_t e;
		e.hits         = hits;
		e.lik          = lik;
		e.phi          = phi;
		e.pt           = pt;
		e.eta          = eta;
		e.charge       = chg;
		e.last_layer   = ll;
		e.last_pattern = lp;
		entry_q = {entry_q, e};
	endfunction

	// hit counts cluster around the threshold so the floor compare matters
	function automatic logic [4:0] pick_hits();
		int h;
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		h = int'(need_hits) + int'($urandom_range(0, 4)) - 2;
		if (h < 0)
			h = 0;
		if (h > 31)
			h = 31;
		return 5'(h);
	endfunction

	function automatic logic [15:0] pick_lik();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1, 2: return 16'($urandom_range(1, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int add_random_set();
		int n_pat;
		int n_ent;
		int cnt;
		logic [4:0] pt;
		logic signed [7:0] eta;
		logic signed [1:0] chg;
		logic ll;
		logic lp;
		cnt = 0;
		n_pat = $urandom_range(1, 4);
		for (int p = 0; p < n_pat; p++) begin
			pt  = 5'($urandom);
			eta = 8'($urandom);
			chg = 2'($urandom);
			n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(REF_LAYERS + 1, REF_LAYERS + 3)
				: $urandom_range(1, REF_LAYERS);
			for (int k = 0; k < n_ent; k++) begin
				ll = (k == n_ent - 1) || ($urandom_range(0, 11) == 0);
				lp = (p == n_pat - 1) && (k == n_ent - 1);
				if (lp && $urandom_range(0, 3) == 0)
					ll = 1'b0;
				add_entry(pick_hits(), pick_lik(), 12'($urandom), pt, eta, chg, ll, lp);
				cnt++;
			end
		end
		return cnt;
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		need_hits = data[4:0];
	endtask

	task automatic drain();
		do @(negedge clk); while (entry_q.size() != 0 || s_tvalid || cand_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input logic [4:0] floor_val, input int n_items);
		int cnt;
		apb_write({REG_MIN_HITS, 2'b00}, {27'd0, floor_val});
		cnt = 0;
		while (cnt < n_items)
			cnt += add_random_set();
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				fold_entry(cur_entry);
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (entry_q.size() != 0) begin
					cur_entry = entry_q.pop_front();
					s_tdata  <= {cur_entry.charge, cur_entry.eta, cur_entry.pt,
						cur_entry.phi, cur_entry.lik, cur_entry.hits};
					s_tuser  <= cur_entry.last_layer;
					s_tlast  <= cur_entry.last_pattern;
					s_tvalid <= 1'b1;
					if (idle_en && $urandom_range(0, 15) == 0)
						src_gap = $urandom_range(1, 15);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_cand(m_tdata);
			if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 19) == 0) begin
				sink_gap = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		need_hits = MIN_HITS_RST;
		clear_pattern();
		clear_set();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, nothing accepted
		add_entry(5'd0, 16'd0, 12'sd0, 5'd9, 8'sd3, 2'sd1, 1'b1, 1'b1);
		// zero likelihood first, tie keeps the earlier entry, fewer hits ignored
		add_entry(5'd5, 16'd0, 12'sd100, 5'd31, -8'sd128, -2'sd1, 1'b0, 1'b0);
		add_entry(5'd5, 16'd200, -12'sd2048, 5'd31, -8'sd128, -2'sd1, 1'b0, 1'b0);
		add_entry(5'd5, 16'd200, 12'sd7, 5'd31, -8'sd128, -2'sd1, 1'b0, 1'b0);
		add_entry(5'd3, 16'd900, 12'sd5, 5'd31, -8'sd128, -2'sd1, 1'b0, 1'b0);
		add_entry(5'd0, 16'hffff, 12'sd9, 5'd31, -8'sd128, -2'sd1, 1'b1, 1'b0);
		// greater likelihood wins, equal does not, pattern left open at the end
		add_entry(5'd5, 16'd300, 12'sd2047, 5'd0, 8'sd127, 2'sd1, 1'b1, 1'b0);
		add_entry(5'd5, 16'd300, 12'sd1, 5'd1, 8'sd0, 2'b10, 1'b1, 1'b0);
		add_entry(5'd4, 16'd0, 12'sd2, 5'd2, -8'sd1, 2'sd0, 1'b0, 1'b1);
		// winner with hits but no likelihood
		add_entry(5'd31, 16'd0, 12'sd33, 5'd12, 8'sd40, 2'sd1, 1'b1, 1'b1);
		// layer index saturates past the last reference layer
		for (int k = 1; k <= REF_LAYERS + 2; k++)
			add_entry(5'(k), 16'd1, 12'(k), 5'd17, 8'sd5, 2'sd0,
				k == REF_LAYERS + 2, k == REF_LAYERS + 2);
		// below the hit floor
		add_entry(5'd2, 16'd5, 12'sd3, 5'd4, 8'sd4, 2'sd1, 1'b1, 1'b1);
		drain();

		run_phase(5'd0, 80);
		run_phase(5'd31, 80);
		run_phase(5'd1, 80);
		run_phase(5'd5, 80);
		run_phase(5'($urandom), 80);
		idle_en = 1'b0;
		run_phase(MIN_HITS_RST, 80);

		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
